FILE: rtl/core/vrc_pkg.sv
`timescale 1ns / 1ps

package vrc_pkg;

    // Geometry of one coarse cell
    localparam int NUM_FINE   = 8;
    localparam int FIELD_BITS = 32;

    // Reciprocal precision: q = 2^RECIP_BITS / a
    localparam int RECIP_BITS = 60;
    localparam int RECIP_W    = RECIP_BITS + 1;
    localparam int RSUM_W     = 64;

    // Quotient bits resolved per pipeline stage
    localparam int DIV_STEP  = 4;
    // Root bits resolved per pipeline stage
    localparam int SQRT_STEP = 4;

    typedef enum logic {
        MODE_VOIGT    = 1'b0,
        MODE_COMBINED = 1'b1
    } avg_mode_t;

endpackage

FILE: rtl/core/vrc_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider, DIV_STEP quotient bits per stage, several lanes
// sharing one valid bit and one sideband word.
module vrc_div #(
    parameter int NUM_W  = 61,
    parameter int DEN_W  = 32,
    parameter int LANES  = 8,
    parameter int SIDE_W = 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            ce,
    input  logic                            in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]     num,
    input  logic [LANES-1:0][DEN_W-1:0]     den,
    input  logic [SIDE_W-1:0]               side,
    output logic                            out_valid,
    output logic [LANES-1:0][NUM_W-1:0]     quot,
    output logic [SIDE_W-1:0]               side_out
);
    import vrc_pkg::*;

    localparam int NS = (NUM_W + DIV_STEP - 1) / DIV_STEP;

    logic                        valid_reg [NS];
    logic [LANES-1:0][DEN_W-1:0] rem_reg   [NS];
    logic [LANES-1:0][DEN_W-1:0] den_reg   [NS];
    logic [LANES-1:0][NUM_W-1:0] nq_reg    [NS];
    logic [SIDE_W-1:0]           side_reg  [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [LANES-1:0][DEN_W-1:0] rem_in, den_in, rem_next;
        logic [LANES-1:0][NUM_W-1:0] nq_in, nq_next;
        logic [SIDE_W-1:0]           side_in;
        logic                        vld_in;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign den_in  = den;
            assign nq_in   = num;
            assign side_in = side;
            assign vld_in  = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign nq_in   = nq_reg[s-1];
            assign side_in = side_reg[s-1];
            assign vld_in  = valid_reg[s-1];
        end

        // Shift dividend bits into the remainder, quotient bits into the low end
        always_comb begin
            logic [DEN_W:0]   t;
            logic [DEN_W-1:0] r;
            logic [NUM_W-1:0] x;
            t        = '0;
            r        = '0;
            x        = '0;
            rem_next = rem_in;
            nq_next  = nq_in;
            for (int l = 0; l < LANES; l++) begin
                r = rem_in[l];
                x = nq_in[l];
                for (int k = 0; k < DIV_STEP; k++) begin
                    if (s * DIV_STEP + k < NUM_W) begin
                        t = {r, x[NUM_W-1]};
                        x = {x[NUM_W-2:0], 1'b0};
                        if (t >= {1'b0, den_in[l]}) begin
                            t    = t - {1'b0, den_in[l]};
                            x[0] = 1'b1;
                        end
                        r = t[DEN_W-1:0];
                    end
                end
                rem_next[l] = r;
                nq_next[l]  = x;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (ce) begin
                valid_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= den_in;
                nq_reg[s]   <= nq_next;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign quot      = nq_reg[NS-1];
    assign side_out  = side_reg[NS-1];

endmodule

FILE: rtl/core/vrc_gmean.sv
`timescale 1ns / 1ps

// floor(sqrt(a*b)): split multiply over two stages, then a pipelined
// digit-by-digit square root, SQRT_STEP root bits per stage.
module vrc_gmean #(
    parameter int VB     = 32,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [VB-1:0]     a,
    input  logic [VB-1:0]     b,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [VB-1:0]     root,
    output logic [SIDE_W-1:0] side_out
);
    import vrc_pkg::*;

    localparam int H  = VB / 2;
    localparam int HW = VB - H;
    localparam int PW = 2 * VB;
    localparam int RW = VB + 3;
    localparam int NQ = (VB + SQRT_STEP - 1) / SQRT_STEP;

    // Partial products
    logic [2*H-1:0]    ll_reg;
    logic [H+HW-1:0]   lh_reg, hl_reg;
    logic [2*HW-1:0]   hh_reg;
    logic              m1_valid_reg;
    logic [SIDE_W-1:0] m1_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
        end else if (ce) begin
            m1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ll_reg      <= a[H-1:0] * b[H-1:0];
            lh_reg      <= (H+HW)'(a[H-1:0]) * (H+HW)'(b[VB-1:H]);
            hl_reg      <= (H+HW)'(a[VB-1:H]) * (H+HW)'(b[H-1:0]);
            hh_reg      <= a[VB-1:H] * b[VB-1:H];
            m1_side_reg <= side;
        end
    end

    // Product sum
    logic [PW-1:0]     prod_next, prod_reg;
    logic              m2_valid_reg;
    logic [SIDE_W-1:0] m2_side_reg;

    assign prod_next = {hh_reg, ll_reg} + (PW'(lh_reg) << H) + (PW'(hl_reg) << H);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_valid_reg <= 1'b0;
        end else if (ce) begin
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg    <= prod_next;
            m2_side_reg <= m1_side_reg;
        end
    end

    // Root stages
    logic              valid_reg [NQ];
    logic [RW-1:0]     rem_reg   [NQ];
    logic [VB-1:0]     root_reg  [NQ];
    logic [PW-1:0]     x_reg     [NQ];
    logic [SIDE_W-1:0] side_reg  [NQ];

    for (genvar s = 0; s < NQ; s++) begin : g_stage
        logic [RW-1:0]     rem_in, rem_next;
        logic [VB-1:0]     root_in, root_next;
        logic [PW-1:0]     x_in, x_next;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = prod_reg;
            assign side_in = m2_side_reg;
            assign vld_in  = m2_valid_reg;
        end else begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign x_in    = x_reg[s-1];
            assign side_in = side_reg[s-1];
            assign vld_in  = valid_reg[s-1];
        end

        // Bring down two radicand bits, try root*4+1
        always_comb begin
            logic [RW-1:0] t;
            logic [RW-1:0] trial;
            logic [VB-1:0] q;
            logic [PW-1:0] x;
            t     = rem_in;
            trial = '0;
            q     = root_in;
            x     = x_in;
            for (int k = 0; k < SQRT_STEP; k++) begin
                if (s * SQRT_STEP + k < VB) begin
                    t     = {t[RW-3:0], x[PW-1:PW-2]};
                    x     = {x[PW-3:0], 2'b00};
                    trial = RW'({q, 2'b01});
                    if (t >= trial) begin
                        t = t - trial;
                        q = {q[VB-2:0], 1'b1};
                    end else begin
                        q = {q[VB-2:0], 1'b0};
                    end
                end
            end
            rem_next  = t;
            root_next = q;
            x_next    = x;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (ce) begin
                valid_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                x_reg[s]    <= x_next;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[NQ-1];
    assign root      = root_reg[NQ-1];
    assign side_out  = side_reg[NQ-1];

endmodule

FILE: rtl/core/voigt_reuss_coarsen.sv
`timescale 1ns / 1ps

// Coarsens one 2x2x2 cell of unsigned Q16.16 values per request. Mode 0 gives
// the arithmetic mean V; mode 1 (reset) gives (V + R + 2*sqrt(V*R)) / 4 with R
// the harmonic mean, or 0 with tuser set if any fine value is zero. The block
// takes one request per clock unless the output stalls, and holds many in flight.
// At VALUE_BITS = 32 the pipeline is: input stage, 16-stage reciprocal divider,
// two sum stages, 16-stage harmonic divider, clamp stage, two multiply stages,
// 8-stage square root and the output register; the two dividers (4 quotient
// bits per stage) and the root (4 bits per stage) set the depth. All stages
// advance together and freeze while a result is held on a stalled output.
module voigt_reuss_coarsen #(
    parameter int VALUE_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    // fine_x0y0z0, fine_x1y0z0, fine_x0y1z0, fine_x1y1z0,
    // fine_x0y0z1, fine_x1y0z1, fine_x0y1z1, fine_x1y1z1 (32 bits each)
    input  logic [255:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // coarse_value
    output logic [31:0]  m_tdata,
    // zero_input
    output logic [0:0]   m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_data,
    input  logic         cfg_valid,
    output logic         cfg_ready
);
    import vrc_pkg::*;

    localparam int VB     = VALUE_BITS;
    localparam int IN_W   = (VB < FIELD_BITS) ? VB : FIELD_BITS;
    localparam int SIDE_W = 2 + IN_W;
    localparam int GS_W   = SIDE_W + VB;
    localparam logic [RECIP_W-1:0] RECIP_ONE = RECIP_W'(1) << RECIP_BITS;
    localparam logic [RSUM_W-1:0]  HARM_NUM  = RSUM_W'(NUM_FINE) << RECIP_BITS;
    localparam logic [VB-1:0]      VMAX      = '1;

    logic ce;
    logic m_valid_reg;

    // Whole pipeline advances unless the output holds an untaken result
    assign ce       = !m_valid_reg || m_tready;
    assign s_tready = ce;

    // Mode register
    avg_mode_t mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_COMBINED;
        end else if (cfg_valid) begin
            mode_reg <= avg_mode_t'(cfg_data);
        end
    end

    // Input stage: mask, arithmetic mean, zero detect
    logic [NUM_FINE-1:0][IN_W-1:0] a_next, a_reg;
    logic [IN_W+2:0]               sum_next;
    logic                          zero_next;
    logic                          in_valid_reg;
    logic [SIDE_W-1:0]             in_side_reg;

    always_comb begin
        sum_next  = '0;
        zero_next = 1'b0;
        for (int i = 0; i < NUM_FINE; i++) begin
            a_next[i] = s_tdata[i*FIELD_BITS +: IN_W];
            sum_next  = sum_next + (IN_W+3)'(a_next[i]);
            if (a_next[i] == '0) begin
                zero_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (ce) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_reg       <= a_next;
            in_side_reg <= {mode_reg == MODE_COMBINED, zero_next, sum_next[IN_W+2:3]};
        end
    end

    // Reciprocals 2^60 / a
    logic [NUM_FINE-1:0][RECIP_W-1:0] recip_num, recip;
    logic                             rc_valid;
    logic [SIDE_W-1:0]                rc_side;

    always_comb begin
        for (int i = 0; i < NUM_FINE; i++) begin
            recip_num[i] = RECIP_ONE;
        end
    end

    vrc_div #(
        .NUM_W  (RECIP_W),
        .DEN_W  (IN_W),
        .LANES  (NUM_FINE),
        .SIDE_W (SIDE_W)
    ) u_recip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (in_valid_reg),
        .num       (recip_num),
        .den       (a_reg),
        .side      (in_side_reg),
        .out_valid (rc_valid),
        .quot      (recip),
        .side_out  (rc_side)
    );

    // Reciprocal sum over two stages
    logic [3:0][RECIP_W:0] pair_reg;
    logic                  pr_valid_reg, qs_valid_reg;
    logic [SIDE_W-1:0]     pr_side_reg, qs_side_reg;
    logic [RSUM_W-1:0]     qsum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pr_valid_reg <= 1'b0;
            qs_valid_reg <= 1'b0;
        end else if (ce) begin
            pr_valid_reg <= rc_valid;
            qs_valid_reg <= pr_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 4; i++) begin
                pair_reg[i] <= (RECIP_W+1)'(recip[2*i]) + (RECIP_W+1)'(recip[2*i+1]);
            end
            pr_side_reg <= rc_side;
            qsum_reg    <= RSUM_W'(pair_reg[0]) + RSUM_W'(pair_reg[1])
                         + RSUM_W'(pair_reg[2]) + RSUM_W'(pair_reg[3]);
            qs_side_reg <= pr_side_reg;
        end
    end

    // Harmonic mean 8*2^60 / Q
    logic [0:0][RSUM_W-1:0] harm_num, harm_den, harm;
    logic                   hm_valid;
    logic [SIDE_W-1:0]      hm_side;

    assign harm_num[0] = HARM_NUM;
    assign harm_den[0] = qsum_reg;

    vrc_div #(
        .NUM_W  (RSUM_W),
        .DEN_W  (RSUM_W),
        .LANES  (1),
        .SIDE_W (SIDE_W)
    ) u_harm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (qs_valid_reg),
        .num       (harm_num),
        .den       (harm_den),
        .side      (qs_side_reg),
        .out_valid (hm_valid),
        .quot      (harm),
        .side_out  (hm_side)
    );

    // Clamp R to the value range
    logic [VB-1:0]     r_reg;
    logic              cl_valid_reg;
    logic [SIDE_W-1:0] cl_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cl_valid_reg <= 1'b0;
        end else if (ce) begin
            cl_valid_reg <= hm_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            r_reg       <= (harm[0] > RSUM_W'(VMAX)) ? VMAX : harm[0][VB-1:0];
            cl_side_reg <= hm_side;
        end
    end

    // Geometric mean sqrt(V*R)
    logic [VB-1:0]   g_root;
    logic            g_valid;
    logic [GS_W-1:0] g_side;

    vrc_gmean #(
        .VB     (VB),
        .SIDE_W (GS_W)
    ) u_gmean (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (cl_valid_reg),
        .a         (VB'(cl_side_reg[IN_W-1:0])),
        .b         (r_reg),
        .side      ({r_reg, cl_side_reg}),
        .out_valid (g_valid),
        .root      (g_root),
        .side_out  (g_side)
    );

    // Final combine and output register
    logic          g_comb, g_zero;
    logic [IN_W-1:0] g_v;
    logic [VB-1:0] g_r;
    logic [VB+1:0] mix;
    logic [31:0]   coarse_next, coarse_reg;
    logic          flag_next, flag_reg;

    assign g_v    = g_side[IN_W-1:0];
    assign g_zero = g_side[IN_W];
    assign g_comb = g_side[IN_W+1];
    assign g_r    = g_side[GS_W-1:SIDE_W];
    assign mix    = (VB+2)'(g_v) + (VB+2)'(g_r) + {1'b0, g_root, 1'b0};

    always_comb begin
        if (!g_comb) begin
            coarse_next = 32'(g_v);
            flag_next   = 1'b0;
        end else if (g_zero) begin
            coarse_next = '0;
            flag_next   = 1'b1;
        end else begin
            coarse_next = 32'(mix[VB+1:2]);
            flag_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= g_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            coarse_reg <= coarse_next;
            flag_reg   <= flag_next;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = coarse_reg;
    assign m_tuser[0] = flag_reg;

    // A flagged result always carries a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("zero_input set with nonzero coarse_value");

    // Reset empties the pipeline
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Output frozen under stall, so no request can enter
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while output stalled");

endmodule

FILE: dv/voigt_reuss_coarsen_tb.sv
`timescale 1ns / 1ps

module voigt_reuss_coarsen_tb;
    import vrc_pkg::*;

    localparam int LATENCY   = 47;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        logic [31:0] value;
        logic        zero_flag;
    } coarse_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [255:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         cfg_data = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;

    avg_mode_t    mode_shadow;
    coarse_t      coarse_q[$];
    int           n_errors = 0;
    int           idle_pct = 36;
    int           wdog = 0;

    voigt_reuss_coarsen #(.VALUE_BITS(32)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
    );

    always #5 aclk = ~aclk;

    // floor(sqrt(a*b)) on the exact product
    function automatic logic [63:0] root_of_product(logic [63:0] a, logic [63:0] b);
        logic [127:0] prod;
        logic [63:0]  r;
        logic [63:0]  c;
        prod = 128'(a) * 128'(b);
        r = '0;
        for (int bit_i = 63; bit_i >= 0; bit_i--) begin
            c = r | (64'd1 << bit_i);
            if (128'(c) * 128'(c) <= prod) r = c;
        end
        return r;
    endfunction

    // Expected coarse value for one cell under the current mode
    function automatic coarse_t coarsen_cell(logic [255:0] cube, avg_mode_t mode);
        logic [63:0] sum, v, q, r, g, res;
        logic [31:0] a;
        logic        any_zero;
        coarse_t     out;
        sum = '0; q = '0; any_zero = 1'b0;
        for (int i = 0; i < NUM_FINE; i++) begin
            a = cube[32*i +: 32];
            sum += 64'(a);
            if (a == 0) any_zero = 1'b1;
            else q += (64'd1 << 60) / 64'(a);
        end
        v = sum >> 3;
        out.zero_flag = 1'b0;
        if (mode == MODE_VOIGT) begin
            out.value = v[31:0];
        end else if (any_zero) begin
            out.value = '0;
            out.zero_flag = 1'b1;
        end else begin
            r = (64'd8 << 60) / q;
            if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
            g = root_of_product(v, r);
            res = (v + r + 2 * g) >> 2;
            if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
            out.value = res[31:0];
        end
        return out;
    endfunction

    // Result side: random stall, compare against oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (coarse_q.size() == 0) begin
                $display("%0t: unexpected result exp=none act=%h/%b", $time, m_tdata, m_tuser);
                n_errors++;
            end else begin
                coarse_t exp_r;
                exp_r = coarse_q.pop_front();
                if (m_tdata !== exp_r.value) begin
                    $display("%0t: coarse_value exp=%h act=%h", $time, exp_r.value, m_tdata);
                    n_errors++;
                end
                if (m_tuser[0] !== exp_r.zero_flag) begin
                    $display("%0t: zero_input exp=%b act=%b", $time, exp_r.zero_flag, m_tuser);
                    n_errors++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Watchdog on cycles with no accepted request or result
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog > WDOG_MAX) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Valid stays high between back-to-back requests, drops only while idling
    task automatic send_cell(logic [255:0] cube);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
        end
        s_tdata  <= cube;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        coarse_q.push_back(coarsen_cell(cube, mode_shadow));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (coarse_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic write_mode(avg_mode_t mode);
        drain();
        cfg_data  <= mode;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_shadow = mode;
    endtask

    function automatic logic [31:0] rand_fine();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return $urandom_range(1, 255);
            2:       return 32'hFFFF_FFFF - $urandom_range(255);
            default: return 32'h0001_0000 + $urandom_range(32'h0008_0000);
        endcase
    endfunction

    function automatic logic [255:0] rand_cell(bit allow_zero);
        logic [255:0] c;
        for (int i = 0; i < NUM_FINE; i++) begin
            c[32*i +: 32] = rand_fine();
            if (c[32*i +: 32] == 0 && !allow_zero) c[32*i +: 32] = 32'd1;
            if (allow_zero && $urandom_range(30) == 0) c[32*i +: 32] = '0;
        end
        return c;
    endfunction

    // Corners of the value range and zero handling in both modes
    task automatic test_directed();
        logic [255:0] c;
        send_cell({8{32'hFFFF_FFFF}});
        send_cell({8{32'h0000_0001}});
        send_cell({8{32'h0001_0000}});
        send_cell('0);
        c = {8{32'h0001_0000}}; c[31:0] = '0;
        send_cell(c);
        c = {8{32'hFFFF_FFFF}}; c[255:224] = 32'd1;
        send_cell(c);
        send_cell({32'h1, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF,
                   32'h1, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF});
        send_cell({8{32'hAAAA_AAAA}});
        send_cell({8{32'h5555_5555}});
        for (int i = 0; i < 3; i++) send_cell(rand_cell(1'b0));
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_cell(rand_cell(1'b1));
    endtask

    initial begin
        mode_shadow = MODE_COMBINED;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        write_mode(MODE_VOIGT);
        test_directed();
        write_mode(MODE_COMBINED);
        test_random(400);
        // no-idle stretch
        idle_pct = 0;
        test_random(200);
        idle_pct = 36;
        write_mode(MODE_VOIGT);
        test_random(300);
        drain();
        write_mode(MODE_COMBINED);
        test_random(380);

        drain();
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
